>>> rtl/glyph_outline_shadow_effect_core_assert.svh
// Assertion helpers for the glyph effect core.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef GLYPH_OUTLINE_SHADOW_EFFECT_CORE_ASSERT_SVH
`define GLYPH_OUTLINE_SHADOW_EFFECT_CORE_ASSERT_SVH

// Same-cycle check: whenever ante holds, cons must hold too.
`define GOSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: whenever ante holds, cons must hold in the next cycle.
`define GOSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gose_pkg.sv
`timescale 1ns / 1ps

package gose_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned ALPHA_LSB  = 24;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] CLEAR_PIXEL  = 32'h0000_0000;

  // Effect selection; the fourth code behaves as passthrough.
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_SHADOW  = 2'd1,
    MODE_OUTLINE = 2'd2
  } effect_mode_t;

  // Register word index, i.e. paddr[3:2].
  typedef enum logic [1:0] {
    REG_EFFECT_MODE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_index_t;

  // One line buffer entry: pixel from the row above plus opacity from two rows up.
  typedef struct packed {
    logic             two_up;
    logic [PIX_W-1:0] pixel;
  } line_entry_t;

endpackage

>>> rtl/glyph_outline_shadow_effect_core.sv
`timescale 1ns / 1ps
// Glyph effect core: streams 32-bit ARGB pixels in raster order and returns one
// effect pixel per input pixel (passthrough, drop shadow or outline), with
// out_frame_last flagging the final pixel of each frame. Throughput is one pixel
// per clock while the output side is not stalling; each pixel passes through two
// register stages, stage 1 and the result register, before reaching out_valid.
// Stage 1 holds the pixel while it waits on the read of the line buffer,
// a MAX_WIDTH x 33-bit memory with one registered read (issued as a pixel is
// taken) and one write (as the pixel leaves the compute stage). Frame size and
// mode registers sit on an APB-style port at byte addresses 0, 4 and 8 and may
// only be changed while no transaction is in flight. The line buffer is not
// cleared after reset; the first row of each frame ignores what it reads.

`include "glyph_outline_shadow_effect_core_assert.svh"

module glyph_outline_shadow_effect_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gose_pkg::PIX_W-1:0]          in_pixel,
  // effect output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gose_pkg::PIX_W-1:0]          out_pixel,
  output logic                                out_frame_last,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gose_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gose_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gose_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CNTW = $clog2(MAX_WIDTH);
  localparam int ROWW = $clog2(MAX_HEIGHT);
  // Comparison widths: wide enough for the size register and the maximum.
  localparam int WDW  = ($clog2(MAX_WIDTH + 1) > gose_pkg::SIZE_W) ?
                        $clog2(MAX_WIDTH + 1) : gose_pkg::SIZE_W;
  localparam int HDW  = ($clog2(MAX_HEIGHT + 1) > gose_pkg::SIZE_W) ?
                        $clog2(MAX_HEIGHT + 1) : gose_pkg::SIZE_W;
  localparam int PW   = gose_pkg::PIX_W;
  localparam int AL   = gose_pkg::ALPHA_LSB;
  localparam int AW   = gose_pkg::ALPHA_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [gose_pkg::MODE_W-1:0] mode_r;
  logic [gose_pkg::SIZE_W-1:0] fwidth_r;
  logic [gose_pkg::SIZE_W-1:0] fheight_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= gose_pkg::MODE_NONE;
      fwidth_r  <= gose_pkg::SIZE_W'(1024);
      fheight_r <= gose_pkg::SIZE_W'(1024);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gose_pkg::REG_EFFECT_MODE:  mode_r    <= pwdata[gose_pkg::MODE_W-1:0];
        gose_pkg::REG_FRAME_WIDTH:  fwidth_r  <= pwdata[gose_pkg::SIZE_W-1:0];
        gose_pkg::REG_FRAME_HEIGHT: fheight_r <= pwdata[gose_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gose_pkg::REG_EFFECT_MODE:
        prdata = {{(gose_pkg::APB_DATA_W - gose_pkg::MODE_W){1'b0}}, mode_r};
      gose_pkg::REG_FRAME_WIDTH:
        prdata = {{(gose_pkg::APB_DATA_W - gose_pkg::SIZE_W){1'b0}}, fwidth_r};
      gose_pkg::REG_FRAME_HEIGHT:
        prdata = {{(gose_pkg::APB_DATA_W - gose_pkg::SIZE_W){1'b0}}, fheight_r};
      default:
        prdata = '0;
    endcase
  end

  // Effective frame size: zero reads as one, anything above the maximum is clipped.
  logic [WDW-1:0] w_eff;
  logic [HDW-1:0] h_eff;

  always_comb begin
    if (fwidth_r == '0) begin
      w_eff = WDW'(1);
    end else if (WDW'(fwidth_r) > WDW'(MAX_WIDTH)) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(fwidth_r);
    end
    if (fheight_r == '0) begin
      h_eff = HDW'(1);
    end else if (HDW'(fheight_r) > HDW'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(fheight_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // s1 holds a taken pixel while the line buffer read completes; the result
  // register is the second stage. A transaction is taken whenever s1 is free
  // or moving on in the same cycle.
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_v_r & (~out_valid | ~out_stall);
  assign in_stall = s1_v_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  // ---------------------------------------------------------------------------
  // Raster position (advanced as each pixel is taken)
  // ---------------------------------------------------------------------------
  logic [CNTW-1:0] col_r;
  logic [ROWW-1:0] row_r;
  logic            last_col;
  logic            last_row;

  assign last_col = (WDW'(col_r) + WDW'(1)) >= w_eff;
  assign last_row = (HDW'(row_r) + HDW'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROWW'(1);
      end else begin
        col_r <= col_r + CNTW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------------
  logic [PW-1:0]   s1_pix_r;
  logic [CNTW-1:0] s1_col_r;
  logic            s1_has_up_r;
  logic            s1_two_up_r;
  logic            s1_has_left_r;
  logic            s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= in_pixel;
      s1_col_r      <= col_r;
      s1_has_up_r   <= row_r != '0;
      s1_two_up_r   <= row_r > ROWW'(1);
      s1_has_left_r <= col_r != '0;
      s1_last_r     <= last_col & last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: read as a pixel is taken, written as it leaves stage 1.
  // With a one-pixel row both happen at the same entry in the same cycle;
  // the written entry is forwarded in that case.
  // ---------------------------------------------------------------------------
  gose_pkg::line_entry_t line_mem [MAX_WIDTH];
  gose_pkg::line_entry_t rd_r;
  gose_pkg::line_entry_t wr_ent;
  gose_pkg::line_entry_t fwd_ent_r;
  gose_pkg::line_entry_t line_ent;
  logic                  fwd_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= wr_ent;
    end
    if (in_acc) begin
      rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= s1_adv & (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_ent_r <= wr_ent;
    end
  end

  assign line_ent = fwd_r ? fwd_ent_r : rd_r;

  // ---------------------------------------------------------------------------
  // Effect logic (stage 1 -> result register)
  // ---------------------------------------------------------------------------
  logic [1:0]    cw_r;     // column opacity at col-1 (bit 0) and col-2 (bit 1)
  logic [PW-1:0] ul_r;     // pixel one row up, one column left
  logic [PW-1:0] above;
  logic          two;
  logic          op_cur;
  logic          op_above;
  logic          col_op;
  logic [1:0]    cw;
  logic          window;
  logic [PW-1:0] ul;
  logic [PW-1:0] result;

  always_comb begin
    above    = s1_has_up_r ? line_ent.pixel : gose_pkg::CLEAR_PIXEL;
    two      = s1_two_up_r & line_ent.two_up;
    op_cur   = s1_pix_r[AL +: AW] != '0;
    op_above = above[AL +: AW] != '0;
    col_op   = op_cur | op_above | two;
    cw       = s1_has_left_r ? cw_r : 2'b00;
    window   = col_op | (cw != 2'b00);
    ul       = (s1_has_left_r & s1_has_up_r) ? ul_r : gose_pkg::CLEAR_PIXEL;

    wr_ent.two_up = op_above;
    wr_ent.pixel  = s1_pix_r;

    case (mode_r)
      gose_pkg::MODE_SHADOW: begin
        // shadow alpha is half the up-left alpha, colour black
        result = op_cur ? s1_pix_r : {1'b0, ul[PW-1:AL+1], {AL{1'b0}}};
      end
      gose_pkg::MODE_OUTLINE: begin
        if (ul[AL +: AW] != '0) begin
          result = ul;
        end else begin
          result = window ? gose_pkg::OPAQUE_BLACK : gose_pkg::CLEAR_PIXEL;
        end
      end
      default: begin
        result = s1_pix_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 2'b00;
      ul_r <= '0;
    end else if (s1_adv) begin
      cw_r <= {cw[0], col_op};
      ul_r <= above;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel      <= result;
      out_frame_last <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // fwd_r only means something while the pixel it was set for sits in stage 1.
  `GOSE_ASSERT_NOW(a_fwd_one_px_row, fwd_r && s1_v_r, w_eff == WDW'(1),
                   "line buffer forward outside a one-pixel row")
  `GOSE_ASSERT_NOW(a_two_up_needs_up, s1_v_r && s1_two_up_r, s1_has_up_r,
                   "two-rows-up flag set without a row above")
  `GOSE_ASSERT_NEXT(a_frame_wrap, in_acc && last_col && last_row,
                    (col_r == '0) && (row_r == '0),
                    "raster position not cleared after frame end")

endmodule
